// File: rtl/ffpd_pkg.sv
package ffpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned CLASS_W = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Depths of the descriptor queue and the result queue.
    localparam int unsigned DESC_DEPTH = 2;
    localparam int unsigned OUT_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LIMIT     = 3'd4;

    localparam logic [BYTE_W-1:0]  RST_HEADER_FIRST   = 8'h55;
    localparam logic [BYTE_W-1:0]  RST_HEADER_SECOND  = 8'h00;
    localparam logic [BYTE_W-1:0]  RST_TRAILER_FIRST  = 8'h00;
    localparam logic [BYTE_W-1:0]  RST_TRAILER_SECOND = 8'hAA;
    localparam logic [COUNT_W-1:0] RST_WORD_LIMIT     = 5'd10;

    localparam logic [BYTE_W-1:0] ID_MAX = 8'h02;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_ID,
        PH_COUNT,
        PH_DATA,
        PH_TRL1,
        PH_TRL2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  header_first;
        logic [BYTE_W-1:0]  header_second;
        logic [BYTE_W-1:0]  trailer_first;
        logic [BYTE_W-1:0]  trailer_second;
        logic [COUNT_W-1:0] word_limit;
    } cfg_t;

    typedef struct packed {
        logic [CLASS_W-1:0] frame_class;
        logic [COUNT_W-1:0] total;
        logic               bank;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    typedef struct packed {
        logic [CLASS_W-1:0] frame_class;
        logic               has_word;
        logic [VALUE_W-1:0] word_value;
        logic [INDEX_W-1:0] word_index;
        logic [COUNT_W-1:0] word_total;
        logic               last;
    } res_t;

endpackage

// File: rtl/framed_float_packet_decoder.sv
// Channel   Direction  Handshake             Payload
// input     in         push / full           rx_byte
// result    out        empty / pop           frame_class, has_word, word_value,
//                                            word_index, word_total, last
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// The parser takes one byte a cycle unless it stalls. With the back end idle, a frame's final
// trailer byte queues its descriptor; the back end pops it and reads the first word from the
// payload RAM, the rest following one a cycle while the result queue has room and the parser
// takes the next frame. An empty frame's single word is made when its descriptor is popped.
// The parser stalls only when it must write a word while both RAM banks hold frames not yet
// drained, or must queue a frame while two are already queued. Reset is asynchronous.
module framed_float_packet_decoder #(
    parameter int unsigned MAX_WORDS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        rx_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        frame_class,
    output logic                              has_word,
    output logic [31:0]                       word_value,
    output logic [3:0]                        word_index,
    output logic [4:0]                        word_total,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);
    import ffpd_pkg::*;

    localparam int unsigned IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int unsigned ADDR_W = IDX_W + 1;
    localparam int unsigned RAM_DEPTH = 2 * (1 << IDX_W);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [31:0]        ram_rdata;

    logic   desc_push;
    desc_t  desc_in;
    logic   desc_pop;
    desc_t  desc_out;
    logic   desc_full;
    logic   desc_empty;

    logic                            res_push;
    res_t                            res_in;
    res_t                            res_out;
    logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;
    rel_t                            rel;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEADER_FIRST:   cfg_next.header_first   = cfg_data;
                CFG_HEADER_SECOND:  cfg_next.header_second  = cfg_data;
                CFG_TRAILER_FIRST:  cfg_next.trailer_first  = cfg_data;
                CFG_TRAILER_SECOND: cfg_next.trailer_second = cfg_data;
                CFG_WORD_LIMIT:     cfg_next.word_limit     = cfg_data[COUNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first   <= RST_HEADER_FIRST;
            cfg_reg.header_second  <= RST_HEADER_SECOND;
            cfg_reg.trailer_first  <= RST_TRAILER_FIRST;
            cfg_reg.trailer_second <= RST_TRAILER_SECOND;
            cfg_reg.word_limit     <= RST_WORD_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ffpd_front #(
        .MAX_WORDS (MAX_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .desc_full (desc_full),
        .desc_push (desc_push),
        .desc      (desc_in),
        .rel       (rel)
    );

    ffpd_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffpd_queue #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (DESC_DEPTH)
    ) u_desc_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .wdata (desc_in),
        .pop   (desc_pop),
        .rdata (desc_out),
        .full  (desc_full),
        .empty (desc_empty),
        .count ()
    );

    ffpd_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_empty (desc_empty),
        .desc       (desc_out),
        .desc_pop   (desc_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_count  (out_count),
        .res_push   (res_push),
        .res        (res_in),
        .rel        (rel)
    );

    ffpd_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .pop   (pop),
        .rdata (res_out),
        .full  (),
        .empty (empty),
        .count (out_count)
    );

    assign frame_class = res_out.frame_class;
    assign has_word    = res_out.has_word;
    assign word_value  = res_out.word_value;
    assign word_index  = res_out.word_index;
    assign word_total  = res_out.word_total;
    assign last        = res_out.last;

endmodule

// File: rtl/ffpd_ram.sv
module ffpd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ffpd_queue.sv
module ffpd_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/ffpd_front.sv
module ffpd_front #(
    parameter int unsigned MAX_WORDS = 16,
    parameter int unsigned ADDR_W    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffpd_pkg::cfg_t      cfg,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          rx_byte,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [31:0]         ram_wdata,
    input  logic                desc_full,
    output logic                desc_push,
    output ffpd_pkg::desc_t     desc,
    input  ffpd_pkg::rel_t      rel
);
    import ffpd_pkg::*;

    localparam int unsigned IDX_W = ADDR_W - 1;
    localparam logic [BYTE_W:0] MAX_LIM = (BYTE_W + 1)'(MAX_WORDS);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CLASS_W-1:0] class_reg;
    logic [CLASS_W-1:0] class_next;
    logic [COUNT_W-1:0] expected_reg;
    logic [COUNT_W-1:0] expected_next;
    logic [COUNT_W-1:0] done_reg;
    logic [COUNT_W-1:0] done_next;
    logic [1:0]         pos_reg;
    logic [1:0]         pos_next;
    logic [23:0]        partial_reg;
    logic [23:0]        partial_next;
    logic               bank_reg;
    logic               bank_next;
    logic [1:0]         busy_reg;
    logic [1:0]         busy_next;

    logic                       accept;
    logic [BYTE_W:0]            limit;
    logic [IDX_W+COUNT_W-1:0]   done_wide;
    logic                       trailer_ok;
    logic                       word_end;

    // The store has two banks, so one frame can be parsed while the previous one drains.
    assign word_end   = (phase_reg == PH_DATA) && (pos_reg == 2'd3);
    assign full       = (word_end && busy_reg[bank_reg]) || ((phase_reg == PH_TRL2) && desc_full);
    assign accept     = push && !full;
    assign limit      = ({4'd0, cfg.word_limit} < MAX_LIM)
                        ? {4'd0, cfg.word_limit} : MAX_LIM;
    assign done_wide  = {{IDX_W{1'b0}}, done_reg};
    assign trailer_ok = (rx_byte == cfg.trailer_second);

    always_comb
    begin
        phase_next    = phase_reg;
        class_next    = class_reg;
        expected_next = expected_reg;
        done_next     = done_reg;
        pos_next      = pos_reg;
        partial_next  = partial_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    done_next    = '0;
                    pos_next     = '0;
                    partial_next = '0;
                    phase_next   = (rx_byte == cfg.header_first) ? PH_HDR2 : PH_HDR1;
                end
                PH_HDR2:
                begin
                    phase_next = (rx_byte == cfg.header_second) ? PH_ID : PH_HDR1;
                end
                PH_ID:
                begin
                    if (rx_byte <= ID_MAX)
                    begin
                        class_next = rx_byte[CLASS_W-1:0];
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_COUNT:
                begin
                    if ({1'b0, rx_byte} > limit)
                    begin
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        expected_next = rx_byte[COUNT_W-1:0];
                        done_next     = '0;
                        pos_next      = '0;
                        partial_next  = '0;
                        phase_next    = (rx_byte == 8'd0) ? PH_TRL1 : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (pos_reg != 2'd3)
                    begin
                        unique case (pos_reg)
                            2'd0:    partial_next[7:0]   = rx_byte;
                            2'd1:    partial_next[15:8]  = rx_byte;
                            default: partial_next[23:16] = rx_byte;
                        endcase
                        pos_next = pos_reg + 1'b1;
                    end
                    else
                    begin
                        done_next    = done_reg + 1'b1;
                        pos_next     = '0;
                        partial_next = '0;
                        if ((done_reg + 1'b1) >= expected_reg)
                        begin
                            phase_next = PH_TRL1;
                        end
                    end
                end
                PH_TRL1:
                begin
                    phase_next = (rx_byte == cfg.trailer_first) ? PH_TRL2 : PH_HDR1;
                end
                PH_TRL2:
                begin
                    phase_next = PH_HDR1;
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_comb
    begin
        ram_we            = accept && word_end;
        ram_waddr         = {bank_reg, done_wide[IDX_W-1:0]};
        ram_wdata         = {rx_byte, partial_reg};
        desc_push         = accept && (phase_reg == PH_TRL2) && trailer_ok;
        desc.frame_class  = class_reg;
        desc.total        = expected_reg;
        desc.bank         = bank_reg;
        bank_next         = bank_reg;
        busy_next         = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        // An empty frame leaves its bank free for the next frame.
        if (desc_push && (expected_reg != '0))
        begin
            busy_next[bank_reg] = 1'b1;
            bank_next           = !bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR1;
            class_reg    <= '0;
            expected_reg <= '0;
            done_reg     <= '0;
            pos_reg      <= '0;
            partial_reg  <= '0;
            bank_reg     <= 1'b0;
            busy_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            class_reg    <= class_next;
            expected_reg <= expected_next;
            done_reg     <= done_next;
            pos_reg      <= pos_next;
            partial_reg  <= partial_next;
            bank_reg     <= bank_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

// File: rtl/ffpd_back.sv
module ffpd_back #(
    parameter int unsigned ADDR_W = 5
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      desc_empty,
    input  ffpd_pkg::desc_t                           desc,
    output logic                                      desc_pop,
    output logic                                      ram_re,
    output logic [ADDR_W-1:0]                         ram_raddr,
    input  logic [31:0]                               ram_rdata,
    input  logic [$clog2(ffpd_pkg::OUT_DEPTH+1)-1:0]  out_count,
    output logic                                      res_push,
    output ffpd_pkg::res_t                            res,
    output ffpd_pkg::rel_t                            rel
);
    import ffpd_pkg::*;

    localparam int unsigned IDX_W = ADDR_W - 1;

    logic               active_reg;
    logic               active_next;
    logic [CLASS_W-1:0] class_reg;
    logic [CLASS_W-1:0] class_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic               bank_reg;
    logic               bank_next;
    logic [COUNT_W-1:0] idx_reg;
    logic [COUNT_W-1:0] idx_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    res_t               pend_reg;
    res_t               pend_next;

    logic                     space;
    logic                     issue;
    logic                     last_read;
    logic [IDX_W+COUNT_W-1:0] idx_wide;

    // A result slot is reserved for the word whose read is still in flight.
    assign space     = (32'(out_count) + 32'(pend_valid_reg)) < 32'(OUT_DEPTH);
    assign issue     = active_reg && space;
    assign last_read = ((idx_reg + 1'b1) == total_reg);
    assign idx_wide  = {{IDX_W{1'b0}}, idx_reg};

    always_comb
    begin
        active_next     = active_reg;
        class_next      = class_reg;
        total_next      = total_reg;
        bank_next       = bank_reg;
        idx_next        = idx_reg;
        pend_valid_next = 1'b0;
        pend_next       = pend_reg;
        if (issue)
        begin
            pend_valid_next      = 1'b1;
            pend_next.frame_class = class_reg;
            pend_next.has_word   = 1'b1;
            pend_next.word_value = '0;
            pend_next.word_index = idx_reg[INDEX_W-1:0];
            pend_next.word_total = total_reg;
            pend_next.last       = last_read;
            idx_next             = idx_reg + 1'b1;
            if (last_read)
            begin
                active_next = 1'b0;
            end
        end
        else if (desc_pop)
        begin
            class_next = desc.frame_class;
            total_next = desc.total;
            bank_next  = desc.bank;
            idx_next   = '0;
            if (desc.total == '0)
            begin
                pend_valid_next       = 1'b1;
                pend_next.frame_class = desc.frame_class;
                pend_next.has_word    = 1'b0;
                pend_next.word_value  = '0;
                pend_next.word_index  = '0;
                pend_next.word_total  = '0;
                pend_next.last        = 1'b1;
            end
            else
            begin
                active_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        desc_pop   = !active_reg && space && !desc_empty;
        ram_re     = issue;
        ram_raddr  = {bank_reg, idx_wide[IDX_W-1:0]};
        res_push   = pend_valid_reg;
        res        = pend_reg;
        if (pend_reg.has_word)
        begin
            res.word_value = ram_rdata;
        end
        rel.valid  = issue && last_read;
        rel.bank   = bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
        total_reg <= total_next;
        bank_reg  <= bank_next;
        pend_reg  <= pend_next;
    end

endmodule

// File: rtl/ffpd_checker.sv
module ffpd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  frame_class,
    input logic        has_word,
    input logic [31:0] word_value,
    input logic [3:0]  word_index,
    input logic [4:0]  word_total,
    input logic        last
);

    // A word that waits must not change until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(word_value) && $stable(frame_class)
                              && $stable(word_index) && $stable(last)))
        else $error("waiting result word changed before it was taken");

    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_class != 2'd3))
        else $error("frame class outside the valid identifiers");

    // An empty frame gives one closing word with no payload.
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_word) |-> (last && (word_total == 5'd0) && (word_index == 4'd0)
                                   && (word_value == 32'd0)))
        else $error("word without payload is not a well-formed empty frame");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && has_word) |-> ({1'b0, word_index} < word_total))
        else $error("word index not below the frame's word count");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && has_word && last) |-> (word_index == 4'(word_total - 5'd1)))
        else $error("last mark not on the frame's final word");

endmodule

bind framed_float_packet_decoder ffpd_checker u_ffpd_checker (.*);

// File: test/framed_float_packet_decoder_tb.sv
`timescale 1ns / 100ps

module framed_float_packet_decoder_tb;
    import ffpd_pkg::*;

    localparam int unsigned WORD_CAP    = 16;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned DRAIN_SLACK = 8;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned SHOWN_ERRORS = 10;
    localparam int          RANDOM_FILL = -1;

    typedef enum logic [1:0] {
        FRAME_CLEAN,
        FRAME_BAD_TRL1,
        FRAME_BAD_TRL2,
        FRAME_CUT
    } frame_flaw_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           rx_byte = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [1:0]           frame_class;
    logic                 has_word;
    logic [31:0]          word_value;
    logic [3:0]           word_index;
    logic [4:0]           word_total;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    // Parser copy kept in step with every accepted byte.
    cfg_t        live_cfg;
    phase_t      prs_phase = PH_HDR1;
    logic [1:0]  prs_class = '0;
    logic [4:0]  prs_total = '0;
    logic [4:0]  prs_done = '0;
    logic [1:0]  prs_pos = '0;
    logic [23:0] prs_partial = '0;
    logic [31:0] prs_store [WORD_CAP];

    res_t        pending_words [$];
    logic [7:0]  tx_bytes [$];
    int          bytes_queued = 0;
    int          send_wait = 0;
    int          take_wait = 0;
    int          take_next = 0;
    int          hold_left = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          idle_cycles = 0;
    int          mismatch_count = 0;
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;

    framed_float_packet_decoder #(
        .MAX_WORDS (WORD_CAP)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .frame_class (frame_class),
        .has_word    (has_word),
        .word_value  (word_value),
        .word_index  (word_index),
        .word_total  (word_total),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int word_cap();
        return (live_cfg.word_limit < WORD_CAP) ? int'(live_cfg.word_limit) : int'(WORD_CAP);
    endfunction

    function automatic int draw_gap(input bit calm);
        if (calm || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        res_t r;
        int   i;
        case (prs_phase)
            PH_HDR1:
            begin
                prs_done = '0;
                prs_pos = '0;
                prs_partial = '0;
                prs_phase = (b == live_cfg.header_first) ? PH_HDR2 : PH_HDR1;
            end
            PH_HDR2:
                prs_phase = (b == live_cfg.header_second) ? PH_ID : PH_HDR1;
            PH_ID:
            begin
                if (b <= ID_MAX)
                begin
                    prs_class = b[1:0];
                    prs_phase = PH_COUNT;
                end
                else
                    prs_phase = PH_HDR1;
            end
            PH_COUNT:
            begin
                if (int'(b) > word_cap())
                    prs_phase = PH_HDR1;
                else
                begin
                    prs_total = b[4:0];
                    prs_done = '0;
                    prs_pos = '0;
                    prs_partial = '0;
                    prs_phase = (b == 8'd0) ? PH_TRL1 : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (prs_pos != 2'd3)
                begin
                    prs_partial = prs_partial | (24'(b) << (8 * prs_pos));
                    prs_pos = prs_pos + 2'd1;
                end
                else
                begin
                    if (prs_done < WORD_CAP)
                        prs_store[prs_done[3:0]] = {b, prs_partial};
                    prs_done = prs_done + 5'd1;
                    prs_pos = '0;
                    prs_partial = '0;
                    if (prs_done >= prs_total)
                        prs_phase = PH_TRL1;
                end
            end
            PH_TRL1:
                prs_phase = (b == live_cfg.trailer_first) ? PH_TRL2 : PH_HDR1;
            PH_TRL2:
            begin
                if (b == live_cfg.trailer_second)
                begin
                    r.frame_class = prs_class;
                    r.word_total = prs_total;
                    if (prs_total == 5'd0)
                    begin
                        r.has_word = 1'b0;
                        r.word_value = '0;
                        r.word_index = '0;
                        r.last = 1'b1;
                        pending_words.insert(pending_words.size(), r);
                    end
                    else
                    begin
                        for (i = 0; i < prs_total; i++)
                        begin
                            r.has_word = 1'b1;
                            r.word_value = prs_store[i];
                            r.word_index = i[3:0];
                            r.last = (i + 1 == prs_total);
                            pending_words.insert(pending_words.size(), r);
                        end
                    end
                end
                prs_phase = PH_HDR1;
            end
            default:
                prs_phase = PH_HDR1;
        endcase
    endtask

    task automatic check_word();
        res_t seen;
        res_t want;
        seen.frame_class = frame_class;
        seen.has_word = has_word;
        seen.word_value = word_value;
        seen.word_index = word_index;
        seen.word_total = word_total;
        seen.last = last;
        if (pending_words.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
                $display("unexpected result: class %0d has %0b value %h index %0d total %0d last %0b",
                         seen.frame_class, seen.has_word, seen.word_value, seen.word_index,
                         seen.word_total, seen.last);
        end
        else
        begin
            want = pending_words.pop_front();
            if (seen !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS)
                begin
                    $display("mismatch: expected class %0d has %0b value %h index %0d total %0d last %0b",
                             want.frame_class, want.has_word, want.word_value, want.word_index,
                             want.word_total, want.last);
                    $display("          actual   class %0d has %0b value %h index %0d total %0d last %0b",
                             seen.frame_class, seen.has_word, seen.word_value, seen.word_index,
                             seen.word_total, seen.last);
                end
            end
        end
    endtask

    // Sender: each byte is followed by a drawn gap; a byte held by full stays put.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            rx_byte <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (push && !full)
                decode_byte(rx_byte);
            if (!push || !full)
            begin
                if (send_wait != 0)
                begin
                    push <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (tx_bytes.size() != 0)
                begin
                    rx_byte <= tx_bytes.pop_front();
                    push <= 1'b1;
                    send_wait <= draw_gap(sender_calm);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Receiver: a drawn pause after each word, and a long hold whenever one is asked for.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            take_wait <= 0;
            hold_left <= 0;
            hold_served <= 0;
        end
        else
        begin
            take_next = take_wait;
            if (pop && !empty)
            begin
                check_word();
                take_next = draw_gap(receiver_calm);
            end
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_left <= LONG_HOLD;
                take_wait <= take_next;
                pop <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                take_wait <= take_next;
                pop <= 1'b0;
            end
            else if (take_next != 0)
            begin
                take_wait <= take_next - 1;
                pop <= 1'b0;
            end
            else
            begin
                take_wait <= 0;
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("framed_float_packet_decoder verification failed");
        $finish;
    end

    task automatic offer(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
        bytes_queued++;
    endtask

    // Waits until every byte is taken and every expected result has come, then lets the
    // block finish any frame that was dropped without results.
    task automatic settle();
        while (tx_bytes.size() != 0 || push || pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HEADER_FIRST:   live_cfg.header_first = val;
            CFG_HEADER_SECOND:  live_cfg.header_second = val;
            CFG_TRAILER_FIRST:  live_cfg.trailer_first = val;
            CFG_TRAILER_SECOND: live_cfg.trailer_second = val;
            CFG_WORD_LIMIT:     live_cfg.word_limit = val[4:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] hf, input logic [7:0] hs,
                                input logic [7:0] tf, input logic [7:0] ts,
                                input logic [7:0] wl);
        settle();
        write_reg(CFG_HEADER_FIRST, hf);
        write_reg(CFG_HEADER_SECOND, hs);
        write_reg(CFG_TRAILER_FIRST, tf);
        write_reg(CFG_TRAILER_SECOND, ts);
        write_reg(CFG_WORD_LIMIT, wl);
    endtask

    task automatic queue_frame(input logic [7:0] id, input logic [7:0] count,
                               input frame_flaw_t flaw, input int fill, input bit pause_mid);
        logic [7:0] fb [$];
        int         k;
        int         n;
        fb.insert(fb.size(), live_cfg.header_first);
        fb.insert(fb.size(), live_cfg.header_second);
        fb.insert(fb.size(), id);
        fb.insert(fb.size(), count);
        if (id <= ID_MAX && int'(count) <= word_cap())
        begin
            for (k = 0; k < 4 * count; k++)
                fb.insert(fb.size(), (fill == RANDOM_FILL) ? rand_byte() : 8'(fill));
            fb.insert(fb.size(), (flaw == FRAME_BAD_TRL1) ? 8'(live_cfg.trailer_first + 8'd1)
                                                          : live_cfg.trailer_first);
            fb.insert(fb.size(), (flaw == FRAME_BAD_TRL2) ? 8'(live_cfg.trailer_second + 8'd1)
                                                          : live_cfg.trailer_second);
        end
        n = (flaw == FRAME_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (k = 0; k < n; k++)
        begin
            offer(fb[k]);
            // The sender stops right after the count byte until the block has drained.
            if (pause_mid && k == 3)
                settle();
        end
        if (flaw == FRAME_CUT)
            offer(rand_byte());
    endtask

    task automatic queue_random_traffic();
        int          pick;
        int          cap;
        frame_flaw_t flaw;
        cap = word_cap();
        pick = $urandom_range(0, 99);
        if (pick < 8)
            offer(rand_byte());
        else if (pick < 12)
            queue_frame(8'($urandom_range(int'(ID_MAX) + 1, 255)), 8'($urandom_range(0, cap)),
                        FRAME_CLEAN, RANDOM_FILL, 1'b0);
        else if (pick < 16)
            queue_frame(8'($urandom_range(0, 2)), 8'($urandom_range(cap + 1, 255)),
                        FRAME_CLEAN, RANDOM_FILL, 1'b0);
        else
        begin
            case ($urandom_range(0, 19))
                0:       flaw = FRAME_BAD_TRL1;
                1:       flaw = FRAME_BAD_TRL2;
                2, 3:    flaw = FRAME_CUT;
                default: flaw = FRAME_CLEAN;
            endcase
            queue_frame(8'($urandom_range(0, 2)),
                        ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, cap))
                                                    : 8'($urandom_range(0, (cap < 3) ? cap : 3)),
                        flaw, RANDOM_FILL, 1'b0);
        end
    endtask

    task automatic run_traffic(input int budget);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            queue_random_traffic();
    endtask

    initial
    begin
        live_cfg.header_first = RST_HEADER_FIRST;
        live_cfg.header_second = RST_HEADER_SECOND;
        live_cfg.trailer_first = RST_TRAILER_FIRST;
        live_cfg.trailer_second = RST_TRAILER_SECOND;
        live_cfg.word_limit = RST_WORD_LIMIT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases at the reset settings.
        queue_frame(8'd2, 8'd0, FRAME_CLEAN, RANDOM_FILL, 1'b0);
        // A second first-header byte breaks the frame and is not taken as a new start.
        offer(live_cfg.header_first);
        offer(live_cfg.header_first);
        offer(live_cfg.header_second);
        queue_frame(ID_MAX + 8'd1, 8'd0, FRAME_CLEAN, RANDOM_FILL, 1'b0);
        queue_frame(8'd1, 8'(RST_WORD_LIMIT) + 8'd1, FRAME_CLEAN, RANDOM_FILL, 1'b0);
        queue_frame(8'd1, 8'd0, FRAME_BAD_TRL2, RANDOM_FILL, 1'b0);
        queue_frame(8'd0, 8'd1, FRAME_CLEAN, 8'hFF, 1'b0);
        queue_frame(8'd1, 8'd1, FRAME_CLEAN, 8'h00, 1'b0);
        run_traffic(40);

        // Opposite extremes of every register, with the largest frame.
        apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 8'd16);
        queue_frame(8'd2, 8'd16, FRAME_CLEAN, RANDOM_FILL, 1'b0);
        queue_frame(8'd1, 8'd2, FRAME_CLEAN, RANDOM_FILL, 1'b1);
        run_traffic(40);

        // No words allowed at all; writes to unused indexes must change nothing.
        apply_config(8'hFF, 8'h00, 8'hAA, 8'hFF, 8'd0);
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_WORD_LIMIT) + 1, (1 << CFG_IDX_W) - 1)),
                  rand_byte());
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), rand_byte());
        run_traffic(30);

        // Limit written as all ones acts as the buffer size; the receiver holds off while
        // the sender runs flat out, so the block fills and pushes back.
        apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 8'hFF);
        sender_calm = 1'b1;
        hold_requests++;
        repeat (6)
            queue_frame(8'd1, 8'd3, FRAME_CLEAN, RANDOM_FILL, 1'b0);
        settle();
        sender_calm = 1'b0;

        apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 8'd17);
        receiver_calm = 1'b1;
        run_traffic(40);
        settle();
        receiver_calm = 1'b0;

        apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                     8'($urandom_range(1, 10)));
        run_traffic(40);

        settle();
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("framed_float_packet_decoder verification clean");
        else
            $display("framed_float_packet_decoder verification failed");
        $finish;
    end

endmodule
